// ===== sv/urlpd_pkg.sv =====
// urlpd_pkg: shared types, character constants and helper functions
// for the url percent decoder. no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package urlpd_pkg;

   localparam int MAX_BYTES = 5;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_BSLASH  = 8'h5c;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_SEMI    = 8'h3b;
   localparam logic [7:0] CH_QUES    = 8'h3f;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_TWO     = 8'h32;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF_HEX  = 8'h66;

   localparam logic [15:0] CAP_RESET = 16'hffff;
   localparam logic [15:0] RESERVE   = 16'd4;

   // an accepted request turns into at most one of these: up to five bytes or a bare end
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                slots;
      logic                      bare;
      logic                      last;
      logic                      ovf;
   } plan_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {4'd0, nib};
      end else begin
         c = CH_UA + {4'd0, nib} - 8'd10;
      end
      return c;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UF) ||
             (c >= CH_LA && c <= CH_LF_HEX);
   endfunction

   function automatic logic first_ok(input logic [7:0] c);
      return (c >= CH_TWO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UF) ||
             (c >= CH_LA && c <= CH_LF_HEX);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = c - CH_ZERO;
      end else if (c >= CH_UA && c <= CH_UF) begin
         v = c - CH_UA + 8'd10;
      end else if (c >= CH_LA && c <= CH_LF_HEX) begin
         v = c - CH_LA + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/urlpd_front.sv =====
// urlpd_front: takes raw bytes, tracks escape state and the output count,
// and turns each request into a plan of output bytes. uses urlpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module urlpd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data,
   output urlpd_pkg::plan_type     plan,
   output logic                    plan_push
);
   import urlpd_pkg::*;

   localparam logic [1:0] PH_TEXT  = 2'd0;
   localparam logic [1:0] PH_PCT   = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;

   typedef struct packed {
      logic [1:0]      n;
      logic [2:0][7:0] b;
      logic            args;
      logic            esc;
   } plain_type;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic        args_ff, args_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] cap_ff, cap_in;

   logic [15:0] limit;
   logic        g0, g1, g2;
   logic [MAX_BYTES-1:0][7:0] obuf;
   logic [2:0]  n;
   logic [15:0] count_sum;
   plain_type   p1, p2;

   // one ordinary-text step; gate says the count is still under the limit
   function automatic plain_type plain_step(input logic [7:0] x, input logic lst,
                                            input logic gate, input logic args);
      plain_type p;
      p = '0;
      p.args = args;
      if (gate) begin
         if (x <= CH_SPACE) begin
            if (x != CH_TAB && x != CH_CR && x != CH_LF) begin
               p.n    = 2'd3;
               p.b[0] = CH_PERCENT;
               p.b[1] = hex_char(x[7:4]);
               p.b[2] = hex_char(x[3:0]);
            end
         end else begin
            if (x == CH_SEMI || x == CH_QUES) begin
               p.args = 1'b1;
            end
            if (x == CH_PERCENT) begin
               if (lst) begin
                  p.n    = 2'd1;
                  p.b[0] = CH_PERCENT;
               end else begin
                  p.esc = 1'b1;
               end
            end else if (x == CH_BSLASH) begin
               p.n    = 2'd1;
               p.b[0] = p.args ? CH_BSLASH : CH_SLASH;
            end else begin
               p.n    = 2'd1;
               p.b[0] = x;
            end
         end
      end
      return p;
   endfunction

   assign limit = (cap_ff > RESERVE) ? (cap_ff - RESERVE) : 16'd0;
   assign g0 = count_ff < limit;
   assign g1 = ({1'b0, count_ff} + 17'd1) < {1'b0, limit};
   assign g2 = ({1'b0, count_ff} + 17'd2) < {1'b0, limit};

   always_comb begin
      obuf     = '0;
      n        = 3'd0;
      phase_in = phase_ff;
      held_in  = held_ff;
      args_in  = args_ff;
      p1       = '0;
      p2       = '0;
      if (g0) begin
         unique case (phase_ff)
            PH_PCT: begin
               if (!in_last && first_ok(in_byte)) begin
                  held_in  = in_byte;
                  phase_in = PH_DIGIT;
               end else begin
                  obuf[0] = CH_PERCENT;
                  p2 = plain_step(in_byte, in_last, g1, args_ff);
                  for (int k = 0; k < 3; k++) begin
                     if (k < int'(p2.n)) obuf[k+1] = p2.b[k];
                  end
                  n        = 3'd1 + {1'b0, p2.n};
                  args_in  = p2.args;
                  phase_in = p2.esc ? PH_PCT : PH_TEXT;
               end
            end
            PH_DIGIT: begin
               if (is_hex(in_byte) && !(held_ff == CH_TWO && in_byte == CH_ZERO)) begin
                  obuf[0]  = {hex_val(held_ff), hex_val(in_byte)};
                  n        = 3'd1;
                  phase_in = PH_TEXT;
               end else begin
                  obuf[0] = CH_PERCENT;
                  // the held digit is never a control byte, so it yields one byte at most
                  p1 = plain_step(held_ff, 1'b0, g1, args_ff);
                  if (p1.n != 2'd0) obuf[1] = p1.b[0];
                  p2 = plain_step(in_byte, in_last, (p1.n != 2'd0) ? g2 : g1, p1.args);
                  for (int k = 0; k < 3; k++) begin
                     if (k < int'(p2.n)) obuf[k + 1 + int'(p1.n)] = p2.b[k];
                  end
                  n        = 3'd1 + {1'b0, p1.n} + {1'b0, p2.n};
                  args_in  = p2.args;
                  phase_in = p2.esc ? PH_PCT : PH_TEXT;
               end
            end
            default: begin
               p2 = plain_step(in_byte, in_last, g0, args_ff);
               for (int k = 0; k < 3; k++) begin
                  if (k < int'(p2.n)) obuf[k] = p2.b[k];
               end
               n        = {1'b0, p2.n};
               args_in  = p2.args;
               phase_in = p2.esc ? PH_PCT : PH_TEXT;
            end
         endcase
      end
   end

   assign count_sum = count_ff + {13'd0, n};

   always_comb begin
      count_in = count_sum;
      if (in_last) begin
         count_in = 16'd0;
      end
      plan.bytes = obuf;
      plan.slots = (n == 3'd0) ? 3'd1 : n;
      plan.bare  = (n == 3'd0);
      plan.last  = in_last;
      plan.ovf   = in_last && (count_sum >= limit);
      plan_push  = accept && ((n != 3'd0) || in_last);
      cap_in     = csr_wr_en ? csr_wr_data : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TEXT;
         held_ff  <= 8'd0;
         args_ff  <= 1'b0;
         count_ff <= 16'd0;
         cap_ff   <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
         if (accept) begin
            if (in_last) begin
               phase_ff <= PH_TEXT;
               held_ff  <= 8'd0;
               args_ff  <= 1'b0;
            end else begin
               phase_ff <= phase_in;
               held_ff  <= held_in;
               args_ff  <= args_in;
            end
            count_ff <= count_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== sv/urlpd_queue.sv =====
// urlpd_queue: small register queue of byte plans between front and back.
// uses urlpd_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module urlpd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire urlpd_pkg::plan_type  push_data,
   input  wire logic                 pop,
   output urlpd_pkg::plan_type       head,
   output logic                      not_empty,
   output logic                      not_full
);
   import urlpd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   plan_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign not_empty = cnt_ff != '0;
   assign not_full  = cnt_ff != FULL_CNT;
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full) else $error("queue push while full");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue pop while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("queue count lost a push");

endmodule
`default_nettype wire

// ===== sv/urlpd_back.sv =====
// urlpd_back: walks each queued plan one byte per cycle, while rsp_tready allows, into the response
// register. uses urlpd_pkg for the plan type.
`timescale 1ns / 1ps
`default_nettype none
module urlpd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire urlpd_pkg::plan_type  head,
   input  wire logic                 head_valid,
   output logic                      head_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast,
   output logic [1:0]                rsp_tuser
);
   import urlpd_pkg::*;

   plan_type    cur_ff, cur_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [2:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        has_ff, has_in;
   logic        ovf_ff, ovf_in;
   logic        out_free, emit, final_slot, finish;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign emit       = cur_valid_ff && out_free;
   assign final_slot = idx_ff == (cur_ff.slots - 3'd1);
   assign finish     = emit && final_slot;
   assign head_pop   = head_valid && (!cur_valid_ff || finish);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (head_pop) begin
         cur_in       = head;
         cur_valid_in = 1'b1;
         idx_in       = 3'd0;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
      end

      out_valid_in = out_valid_ff && !rsp_tready;
      byte_in      = byte_ff;
      last_in      = last_ff;
      has_in       = has_ff;
      ovf_in       = ovf_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         byte_in      = cur_ff.bare ? 8'd0 : cur_ff.bytes[idx_ff];
         has_in       = !cur_ff.bare;
         last_in      = final_slot && cur_ff.last;
         ovf_in       = final_slot && cur_ff.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      has_ff  <= has_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {ovf_ff, has_ff};

endmodule
`default_nettype wire

// ===== sv/url_percent_decoder_unit.sv =====
// url_percent_decoder_unit: top level of the url percent decoder, front
// classifier, plan queue and byte emitter. uses urlpd_pkg and its submodules.
// a request is written to the plan queue, loaded into the emitter's current plan and
// then into the output register before rsp_tvalid rises.
// throughput: one result byte per cycle from the emitter while rsp_tready allows; a
// plan holds 1 to 5 output slots, so plain text runs at one request per cycle unless stalled.
// a request that yields nothing pushes no plan unless it ends the string.
// reset is synchronous, active high: escape state, count and queue clear,
// and the output capacity returns to 65535.
`timescale 1ns / 1ps
`default_nettype none
module url_percent_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] in_byte
   input  wire logic         req_tlast,   // in_last
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,   // out_last
   output logic [1:0]        rsp_tuser,   // [0] has_byte, [1] overflow
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data  // output_capacity
);
   import urlpd_pkg::*;

   plan_type plan, head;
   logic     plan_push, accept, q_not_empty, q_not_full, head_pop;

   assign req_tready = q_not_full;
   assign accept     = req_tvalid && q_not_full;

   urlpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .plan        (plan),
      .plan_push   (plan_push)
   );

   urlpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (plan_push),
      .push_data (plan),
      .pop       (head_pop),
      .head      (head),
      .not_empty (q_not_empty),
      .not_full  (q_not_full)
   );

   urlpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (q_not_empty),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
